[rtl/rc3_pkg.sv]
// Package for the 3x3 repair clamp: transaction payload types, register
// indexes, reset values and the per-item step flags.
// No dependencies.
package rc3_pkg;

	localparam int PIX_W   = 8;
	localparam int WIN_N   = 9;
	localparam int FW_BITS = 13;
	localparam int FH_BITS = 16;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] pix_src;
		logic [PIX_W-1:0] pix_ref;
	} rc3_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix_out;
		logic             frame_last;
	} rc3_out_t;

	// what one accepted item does, decided from position state and its action
	typedef struct packed {
		logic is_data;
		logic emit;
		logic full;
		logic interior;
		logic last;
	} rc3_step_t;

endpackage

[rtl/rc3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and write to one address in the same cycle return the old word.
// No dependencies.
module rc3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rc3_clamp.sv]
// Clamps a pixel to the second-smallest and second-largest of nine window values.
// Depends on rc3_pkg.
module rc3_clamp
	import rc3_pkg::*;
(
	input  logic [WIN_N-1:0][PIX_W-1:0] win,
	input  logic [PIX_W-1:0]            pix,
	output logic [PIX_W-1:0]            clamped
);

	logic [WIN_N-1:0][3:0] rank;
	logic [PIX_W-1:0]      lo;
	logic [PIX_W-1:0]      hi;

	// rank with ties broken by position, so ranks form a permutation
	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN_N; j++) begin
				if (j != i) begin
					rank[i] = rank[i] + 4'((win[j] < win[i]) ||
						((win[j] == win[i]) && (j < i)));
				end
			end
		end
	end

	always_comb begin
		lo = '0;
		hi = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (rank[i] == 4'd1) begin
				lo = lo | win[i];
			end
			if (rank[i] == 4'(WIN_N - 2)) begin
				hi = hi | win[i];
			end
		end
	end

	always_comb begin
		if (pix > hi) begin
			clamped = hi;
		end else if (pix < lo) begin
			clamped = lo;
		end else begin
			clamped = pix;
		end
	end

endmodule

[rtl/rc3_ctrl.sv]
// Position and pending-result tracking: input/output raster counters, result delay
// count and frame-tail drain count. Decides per transaction whether a result leaves.
// Depends on rc3_pkg.
module rc3_ctrl
	import rc3_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic               step,
	input  logic               action,
	input  logic [FW_BITS-1:0] frame_width,
	input  logic [FH_BITS-1:0] frame_height,
	output logic [CW-1:0]      in_col,
	output logic [CW-1:0]      out_col,
	output rc3_step_t          info
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	logic [CW-1:0]      in_col_q, out_col_q, in_col_n, out_col_n;
	logic [FH_BITS-1:0] in_row_q, out_row_q, in_row_n, out_row_n;
	logic [PW-1:0]      pending_q, tail_q, pend_n, tail_n;
	logic [WW-1:0]      w_eff;
	logic [FH_BITS-1:0] h_eff;
	logic               is_flush, tail_any, full, emit;
	logic               in_col_wrap, out_col_wrap, in_row_wrap, out_row_wrap;

	always_comb begin
		if (frame_width == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width);
		end
	end

	assign h_eff    = (frame_height == '0) ? FH_BITS'(1) : frame_height;
	assign is_flush = (action == ACT_FLUSH);
	assign tail_any = (tail_q != '0);
	assign full     = (pending_q == PW'(w_eff) + PW'(1));
	assign emit     = is_flush ? tail_any : (tail_any || full);

	assign in_col_wrap  = (WW'(in_col_q) + WW'(1)) >= w_eff;
	assign out_col_wrap = (WW'(out_col_q) + WW'(1)) >= w_eff;
	assign in_row_wrap  = ({1'b0, in_row_q} + 17'd1) >= {1'b0, h_eff};
	assign out_row_wrap = ({1'b0, out_row_q} + 17'd1) >= {1'b0, h_eff};

	always_comb begin
		info.is_data  = !is_flush;
		info.emit     = emit;
		info.full     = full;
		info.interior = (w_eff >= WW'(3)) && (h_eff >= FH_BITS'(3)) &&
			(out_row_q != '0) && (out_row_q <= h_eff - FH_BITS'(2)) &&
			(out_col_q != '0) && (WW'(out_col_q) <= w_eff - WW'(2));
		info.last     = (out_row_q == h_eff - FH_BITS'(1)) &&
			(WW'(out_col_q) == w_eff - WW'(1));
	end

	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		out_col_n = out_col_q;
		out_row_n = out_row_q;
		pend_n    = pending_q;
		tail_n    = tail_q;
		if (is_flush) begin
			if (tail_any) begin
				pend_n = pending_q - PW'(1);
				tail_n = tail_q - PW'(1);
			end
		end else begin
			if (emit) begin
				if (tail_any) begin
					tail_n = tail_q - PW'(1);
				end
			end else begin
				pend_n = pending_q + PW'(1);
			end
			if (in_col_wrap) begin
				in_col_n = '0;
				if (in_row_wrap) begin
					in_row_n = '0;
					tail_n   = pend_n;   // frame complete: all pending now drain
				end else begin
					in_row_n = in_row_q + FH_BITS'(1);
				end
			end else begin
				in_col_n = in_col_q + CW'(1);
			end
		end
		if (emit) begin
			if (out_col_wrap) begin
				out_col_n = '0;
				out_row_n = out_row_wrap ? '0 : out_row_q + FH_BITS'(1);
			end else begin
				out_col_n = out_col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			tail_q    <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			tail_q    <= '0;
		end else if (step) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			out_col_q <= out_col_n;
			out_row_q <= out_row_n;
			pending_q <= pend_n;
			tail_q    <= tail_n;
		end
	end

	assign in_col  = in_col_q;
	assign out_col = out_col_q;

	a_tail_within_pending: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= pending_q)
		else $error("tail count exceeds pending count");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PW'(w_eff) + PW'(1))
		else $error("pending count beyond one row plus one");

	a_fill_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		step && !restart && !is_flush && !emit |=> pending_q == $past(pending_q) + PW'(1))
		else $error("pixel without result did not add to pending count");

endmodule

[rtl/repair_clamp_3x3_second_extremes.sv]
// 3x3 repair clamp (second extremes) on a raster pixel stream.
// Channels: pix_valid/pix_ready carry rc3_in_t transactions, either a source and
// reference pixel pair (action pixel) or a flush tick; res_valid/res_ready carry
// rc3_out_t results in raster order, frame_last marking the final pixel of a frame.
// APB port: frame_width at 0x0, frame_height at 0x4; a write restarts the frame
// and drops pending results; the user writes only while the block is idle (unenforced).
// Each interior result is the source pixel clamped to the second-smallest and
// second-largest of the reference 3x3 window; border pixels pass the source.
// A result is caused by the pixel transaction arriving one row plus one pixel
// after its own; after a frame's last pixel, flushes or next-frame pixels drain
// the tail one per transaction. Flush with no tail pending gives nothing.
// Timing: one transaction per clock while res_* is not stalled; a result passes
// from its transaction through the line-store read stage, then the output register.
// Reset: no pending results, 640 x 480, window cleared; line stores undefined.
// Stall: the output register holds its result; the stage behind it keeps taking
// transactions until it holds a result-bearing one, then pix_ready drops.
// Depends on rc3_pkg, rc3_ctrl, rc3_ram, rc3_clamp.
module repair_clamp_3x3_second_extremes
	import rc3_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  rc3_in_t     pix_item,
	output logic        res_valid,
	input  logic        res_ready,
	output rc3_out_t    res_item
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic               cfg_wr;

	logic               pix_accept, s1_load, s1_go;
	rc3_step_t          step;
	logic [CW-1:0]      in_col, out_col;

	logic               s1_v_q;
	rc3_step_t          s1_info_q;
	logic [CW-1:0]      s1_col_q;
	logic [PIX_W-1:0]   s1_ref_q;
	logic               s1_byp_q;
	logic [2*PIX_W-1:0] s1_byp_word_q;

	logic [2*PIX_W-1:0] ref_rd;
	logic [PIX_W-1:0]   srca_rd, srcb_rd;
	logic [PIX_W-1:0]   above_s1, two_s1;

	logic [WIN_N-1:0][PIX_W-1:0] win_q, win_n, win_use;
	logic [PIX_W-1:0]   src_hold_q, s_pix, clamped;

	logic               res_valid_q;
	rc3_out_t           res_item_q;

	// configuration
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {{(32-FW_BITS){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT: prdata = {{(32-FH_BITS){1'b0}}, frame_height_q};
			default:          prdata = '0;
		endcase
	end

	// stage 0: position control, line-store reads
	assign s1_go      = s1_v_q && (!s1_info_q.emit || !res_valid_q || res_ready);
	assign pix_ready  = !s1_v_q || s1_go;
	assign pix_accept = pix_valid && pix_ready;
	assign s1_load    = pix_accept && (step.is_data || step.emit);

	rc3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_wr),
		.step         (pix_accept),
		.action       (pix_item.action),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.in_col       (in_col),
		.out_col      (out_col),
		.info         (step)
	);

	// reference rows: {row above, row two above}, rewritten as the reading item leaves stage 1
	rc3_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_ref_rows (
		.clk   (clk),
		.we    (s1_go && s1_info_q.is_data),
		.waddr (s1_col_q),
		.wdata ({s1_ref_q, above_s1}),
		.re    (pix_accept),
		.raddr (in_col),
		.rdata (ref_rd)
	);

	// source delay row, two copies: one read at the input column, one at the output column
	rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_src_in (
		.clk   (clk),
		.we    (pix_accept && step.is_data),
		.waddr (in_col),
		.wdata (pix_item.pix_src),
		.re    (pix_accept && step.is_data),
		.raddr (in_col),
		.rdata (srca_rd)
	);

	rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_src_out (
		.clk   (clk),
		.we    (pix_accept && step.is_data),
		.waddr (in_col),
		.wdata (pix_item.pix_src),
		.re    (pix_accept),
		.raddr (out_col),
		.rdata (srcb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q    <= 1'b0;
			s1_info_q <= '0;
		end else if (pix_ready) begin
			s1_v_q <= s1_load;
			if (s1_load) begin
				s1_info_q <= step;
			end
		end
	end

	// same column back to back (one-pixel rows): take the word still being written
	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_col_q      <= in_col;
			s1_ref_q      <= pix_item.pix_ref;
			s1_byp_q      <= s1_v_q && s1_info_q.is_data && (s1_col_q == in_col);
			s1_byp_word_q <= {s1_ref_q, above_s1};
		end
	end

	// stage 1: window shift, selection, clamp
	assign above_s1 = s1_byp_q ? s1_byp_word_q[2*PIX_W-1:PIX_W] : ref_rd[2*PIX_W-1:PIX_W];
	assign two_s1   = s1_byp_q ? s1_byp_word_q[PIX_W-1:0]       : ref_rd[PIX_W-1:0];

	always_comb begin
		win_n[0] = win_q[1];
		win_n[1] = win_q[2];
		win_n[2] = two_s1;
		win_n[3] = win_q[4];
		win_n[4] = win_q[5];
		win_n[5] = above_s1;
		win_n[6] = win_q[7];
		win_n[7] = win_q[8];
		win_n[8] = s1_ref_q;
	end

	assign win_use = s1_info_q.is_data ? win_n : win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go && s1_info_q.is_data) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_info_q.is_data) begin
			src_hold_q <= srca_rd;
		end
	end

	// delay at full depth: the oldest source was read out by the previous pixel
	assign s_pix = s1_info_q.full ? src_hold_q : srcb_rd;

	rc3_clamp u_clamp (
		.win     (win_use),
		.pix     (s_pix),
		.clamped (clamped)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && s1_info_q.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_info_q.emit) begin
			res_item_q.pix_out    <= s1_info_q.interior ? clamped : s_pix;
			res_item_q.frame_last <= s1_info_q.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && s1_info_q.emit && res_valid_q && !res_ready |-> !pix_ready)
		else $error("input taken while a result-bearing stage is blocked");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && s1_info_q.emit |=> res_valid_q)
		else $error("result left stage one but output register is empty");

	a_flush_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !s1_info_q.is_data |=> win_q == $past(win_q))
		else $error("flush transaction moved the window");

endmodule
